>>> hdl/mas_pkg.sv
// ---------------------------------------------------------------------------
// Manhattan assignment solver package
// Shared state types, datapath operation codes and register constants.
// ---------------------------------------------------------------------------
package mas_pkg;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_RESET = 5'd16;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BUILD,
    ST_COLRED,
    ST_DRAIN,
    ST_MATCH,
    ST_COVER,
    ST_CMIN,
    ST_DECIDE,
    ST_ADJ,
    ST_OUT
  } st_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MIN,
    OP_SUB,
    OP_BEST,
    OP_ADJ
  } op_t;

  typedef enum logic [1:0] {
    MT_IDLE,
    MT_ROOT,
    MT_SEARCH,
    MT_UNWIND
  } mt_t;

  typedef struct packed {
    logic done;
    logic complete;
  } mt_stat_t;

endpackage

>>> hdl/manhattan_assignment_solver.sv
// Loading takes one point per accepted transfer; the solve after the final point
// runs the build and reductions, then per cover round a matching search
// (one step per cycle) plus sweeps through the single cost memory read port,
// then the output transfers. Items are taken one per cycle only
// while loading. Reset is synchronous, active low: counts clear, N becomes 16.
// ---------------------------------------------------------------------------
// Manhattan assignment solver
// Minimum-cost city to plant assignment by the Hungarian method, run on one
// shared cost unit over a cost matrix memory under a small sequencer.
// ---------------------------------------------------------------------------
module manhattan_assignment_solver #(
  parameter int MAX_POINTS = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // coord_x, coord_y
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]         in_tdata,
  // req_type
  input  logic                                      in_tuser,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // city_index, plant_index
  output logic [((2*$clog2(MAX_POINTS)+7)/8)*8-1:0] out_tdata,
  output logic                                      out_tlast,
  input  logic                                      cfg_we,
  input  logic [mas_pkg::PC_W-1:0]                  cfg_wdata
);
  import mas_pkg::*;

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int COST_W = COORD_BITS + 4;
  localparam int DEPTH  = MAX_POINTS * MAX_POINTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int OUT_W  = ((2*IDX_W+7)/8)*8;
  localparam logic [CNT_W-1:0] NO_M = CNT_W'(MAX_POINTS);

  st_t                    st_r, st_nxt, ret_r, ret_nxt;
  logic [PC_W-1:0]        pc_r, pc_nxt;
  logic [CNT_W-1:0]       ccnt_r, ccnt_nxt, pcnt_r, pcnt_nxt;
  logic signed [COORD_BITS-1:0] cx_r [MAX_POINTS];
  logic signed [COORD_BITS-1:0] cy_r [MAX_POINTS];
  logic signed [COORD_BITS-1:0] px_r [MAX_POINTS];
  logic signed [COORD_BITS-1:0] py_r [MAX_POINTS];
  logic [MAX_POINTS-1:0]  zero_r [MAX_POINTS];
  logic [IDX_W-1:0]       sr_r, sr_nxt, sc_r, sc_nxt, j_r, j_nxt;
  logic                   pass_r, pass_nxt, chg_r, chg_nxt, mrun_r, mrun_nxt;
  logic [MAX_POINTS-1:0]  rm_r, rm_nxt, cm_r, cm_nxt;
  logic [COST_W-1:0]      acc_r, acc_nxt;
  logic                   found_r, found_nxt;
  op_t                    d_op_r, d_op_nxt;
  logic                   d_mem_r, d_mem_nxt, d_first_r, d_first_nxt;
  logic [IDX_W-1:0]       d_row_r, d_row_nxt, d_col_r, d_col_nxt;
  logic [COST_W-1:0]      d_cost_r, d_cost_nxt;

  logic [CNT_W-1:0]       n_act, ccnt_inc, pcnt_inc;
  logic [IDX_W-1:0]       nl, irow, icol, zaddr, mrow;
  logic [MAX_POINTS-1:0]  act, zrow, newc;
  logic                   in_acc, ld_city, ld_plant, trigger;
  logic                   c_last, r_last, two, sweep_end, issuing;
  logic [COORD_BITS-1:0]  x_in, y_in, adx, ady;
  logic signed [COORD_BITS:0] dx, dy, ndx, ndy;
  logic [COORD_BITS:0]    cost_sum;
  logic [COST_W-1:0]      rdata, a_op, alu_sum;
  logic                   alu_add, alu_less, mr, mc;
  logic                   we;
  logic [ADDR_W-1:0]      waddr, raddr;
  logic [COST_W-1:0]      wdata;
  logic [CNT_W-1:0]       match_q;
  logic [MAX_POINTS-1:0][CNT_W-1:0] mm;
  logic [MAX_POINTS-1:0]  matched;
  mt_stat_t               mstat;
  logic                   mstart;

  always_comb begin
    if (pc_r == '0) begin
      n_act = CNT_W'(1);
    end else if (int'(pc_r) > MAX_POINTS) begin
      n_act = CNT_W'(MAX_POINTS);
    end else begin
      n_act = CNT_W'(pc_r);
    end
  end
  assign nl = IDX_W'(n_act - CNT_W'(1));

  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      act[i] = (CNT_W'(i) < n_act);
    end
  end

  // Load side.
  assign in_tready = (st_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign x_in      = in_tdata[COORD_BITS-1:0];
  assign y_in      = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign ld_city   = in_acc && !in_tuser && (ccnt_r < n_act);
  assign ld_plant  = in_acc && in_tuser && (pcnt_r < n_act);
  assign ccnt_inc  = ccnt_r + CNT_W'(ld_city);
  assign pcnt_inc  = pcnt_r + CNT_W'(ld_plant);
  assign trigger   = in_acc && (ccnt_inc == n_act) && (pcnt_inc == n_act);

  // Sweep counters: the build and column reduction make two passes per line.
  assign two       = (st_r == ST_BUILD) || (st_r == ST_COLRED);
  assign c_last    = (sc_r == nl);
  assign r_last    = (sr_r == nl);
  assign sweep_end = c_last && r_last && (!two || pass_r);
  assign issuing   = (st_r == ST_BUILD) || (st_r == ST_COLRED) ||
                     (st_r == ST_CMIN) || (st_r == ST_ADJ);
  assign irow      = (st_r == ST_COLRED) ? sc_r : sr_r;
  assign icol      = (st_r == ST_COLRED) ? sr_r : sc_r;
  assign raddr     = ADDR_W'(irow) * ADDR_W'(MAX_POINTS) + ADDR_W'(icol);

  // Manhattan distance of plant sr and city sc.
  assign dx  = {px_r[sr_r][COORD_BITS-1], px_r[sr_r]} - {cx_r[sc_r][COORD_BITS-1], cx_r[sc_r]};
  assign dy  = {py_r[sr_r][COORD_BITS-1], py_r[sr_r]} - {cy_r[sc_r][COORD_BITS-1], cy_r[sc_r]};
  assign ndx = -dx;
  assign ndy = -dy;
  assign adx = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
  assign ady = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
  assign cost_sum = (COORD_BITS+1)'(adx) + (COORD_BITS+1)'(ady);

  // Data stage through the shared unit.
  assign a_op    = d_mem_r ? rdata : d_cost_r;
  assign mr      = rm_r[d_row_r];
  assign mc      = cm_r[d_col_r];
  assign alu_add = (d_op_r == OP_ADJ) && !mr && mc;
  assign waddr   = ADDR_W'(d_row_r) * ADDR_W'(MAX_POINTS) + ADDR_W'(d_col_r);
  assign wdata   = alu_sum;
  assign we      = (d_op_r == OP_SUB) || ((d_op_r == OP_ADJ) && (mr != mc));

  mas_alu #(.W(COST_W)) u_alu (
    .a    (a_op),
    .b    (acc_r),
    .add  (alu_add),
    .sum  (alu_sum),
    .less (alu_less)
  );

  mas_cost_ram #(.DEPTH(DEPTH), .WIDTH(COST_W)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign zaddr  = (st_r == ST_MATCH) ? mrow : sr_r;
  assign zrow   = zero_r[zaddr];
  assign mstart = (st_r == ST_MATCH) && !mrun_r;

  mas_match #(.MAX_POINTS(MAX_POINTS)) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mstart),
    .n_act     (n_act),
    .zero_row  (zrow),
    .row_q     (mrow),
    .rd_col    (j_r),
    .match_q   (match_q),
    .match_o   (mm),
    .matched_o (matched),
    .stat      (mstat)
  );

  assign newc = rm_r[sr_r] ? (zrow & ~cm_r & act) : '0;

  // Result side.
  assign out_tvalid = (st_r == ST_OUT);
  assign out_tdata  = OUT_W'({match_q[IDX_W-1:0], j_r});
  assign out_tlast  = (j_r == nl);

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_LOAD: begin
        if (trigger) begin
          st_nxt = ST_BUILD;
        end
      end
      ST_BUILD, ST_COLRED, ST_CMIN, ST_ADJ: begin
        if (sweep_end) begin
          st_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: st_nxt = ret_r;
      ST_MATCH: begin
        if (mrun_r && mstat.done) begin
          st_nxt = mstat.complete ? ST_OUT : ST_COVER;
        end
      end
      ST_COVER: begin
        if (r_last && !(chg_r || (newc != '0))) begin
          st_nxt = ST_CMIN;
        end
      end
      ST_DECIDE: st_nxt = (found_r && (acc_r != '0)) ? ST_ADJ : ST_MATCH;
      ST_OUT: begin
        if (out_tready && out_tlast) begin
          st_nxt = ST_LOAD;
        end
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  // Counters, marks and data stage.
  always_comb begin
    pc_nxt      = pc_r;
    ccnt_nxt    = ccnt_r;
    pcnt_nxt    = pcnt_r;
    sr_nxt      = sr_r;
    sc_nxt      = sc_r;
    pass_nxt    = pass_r;
    chg_nxt     = chg_r;
    rm_nxt      = rm_r;
    cm_nxt      = cm_r;
    acc_nxt     = acc_r;
    found_nxt   = found_r;
    j_nxt       = j_r;
    mrun_nxt    = mrun_r;
    ret_nxt     = ret_r;
    d_op_nxt    = OP_NONE;
    d_mem_nxt   = (st_r != ST_BUILD);
    d_first_nxt = (sc_r == '0);
    d_row_nxt   = irow;
    d_col_nxt   = icol;
    d_cost_nxt  = COST_W'(cost_sum);

    if (st_r == ST_LOAD) begin
      ccnt_nxt = ccnt_inc;
      pcnt_nxt = pcnt_inc;
      if (cfg_we) begin
        pc_nxt   = cfg_wdata;
        ccnt_nxt = '0;
        pcnt_nxt = '0;
      end
      if (trigger) begin
        ccnt_nxt = '0;
        pcnt_nxt = '0;
        sr_nxt   = '0;
        sc_nxt   = '0;
        pass_nxt = 1'b0;
      end
    end

    if (issuing) begin
      case (st_r)
        ST_BUILD, ST_COLRED: d_op_nxt = pass_r ? OP_SUB : OP_MIN;
        ST_CMIN:             d_op_nxt = OP_BEST;
        ST_ADJ:              d_op_nxt = OP_ADJ;
        default:             d_op_nxt = OP_NONE;
      endcase
      if (c_last) begin
        sc_nxt = '0;
        if (two && !pass_r) begin
          pass_nxt = 1'b1;
        end else begin
          pass_nxt = 1'b0;
          sr_nxt   = r_last ? '0 : (sr_r + IDX_W'(1));
        end
      end else begin
        sc_nxt = sc_r + IDX_W'(1);
      end
      if (sweep_end) begin
        case (st_r)
          ST_BUILD:  ret_nxt = ST_COLRED;
          ST_COLRED: ret_nxt = ST_MATCH;
          ST_CMIN:   ret_nxt = ST_DECIDE;
          ST_ADJ:    ret_nxt = ST_MATCH;
          default:   ret_nxt = ret_r;
        endcase
      end
    end

    case (d_op_r)
      OP_MIN: begin
        if (d_first_r || alu_less) begin
          acc_nxt = a_op;
        end
      end
      OP_BEST: begin
        if (mr && !mc && (!found_r || alu_less)) begin
          acc_nxt   = a_op;
          found_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    if (st_r == ST_MATCH) begin
      mrun_nxt = 1'b1;
      if (mrun_r && mstat.done) begin
        mrun_nxt = 1'b0;
        j_nxt    = '0;
        rm_nxt   = ~matched & act;
        cm_nxt   = '0;
        sr_nxt   = '0;
        chg_nxt  = 1'b0;
      end
    end

    // Koenig marking: marked rows mark their zero columns, whose matched
    // rows become marked in turn, until a full pass adds nothing.
    if (st_r == ST_COVER) begin
      cm_nxt  = cm_r | newc;
      chg_nxt = chg_r || (newc != '0);
      for (int c = 0; c < MAX_POINTS; c++) begin
        if (newc[c] && (mm[c] != NO_M)) begin
          rm_nxt[mm[c][IDX_W-1:0]] = 1'b1;
        end
      end
      if (r_last) begin
        sr_nxt  = '0;
        sc_nxt  = '0;
        chg_nxt = 1'b0;
        if (!(chg_r || (newc != '0))) begin
          found_nxt = 1'b0;
        end
      end else begin
        sr_nxt = sr_r + IDX_W'(1);
      end
    end

    if (st_r == ST_DECIDE) begin
      sr_nxt = '0;
      sc_nxt = '0;
    end

    if ((st_r == ST_OUT) && out_tready) begin
      j_nxt = j_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_LOAD;
      ret_r   <= ST_MATCH;
      pc_r    <= PC_RESET;
      ccnt_r  <= '0;
      pcnt_r  <= '0;
      sr_r    <= '0;
      sc_r    <= '0;
      pass_r  <= 1'b0;
      chg_r   <= 1'b0;
      rm_r    <= '0;
      cm_r    <= '0;
      found_r <= 1'b0;
      j_r     <= '0;
      mrun_r  <= 1'b0;
      d_op_r  <= OP_NONE;
    end else begin
      st_r    <= st_nxt;
      ret_r   <= ret_nxt;
      pc_r    <= pc_nxt;
      ccnt_r  <= ccnt_nxt;
      pcnt_r  <= pcnt_nxt;
      sr_r    <= sr_nxt;
      sc_r    <= sc_nxt;
      pass_r  <= pass_nxt;
      chg_r   <= chg_nxt;
      rm_r    <= rm_nxt;
      cm_r    <= cm_nxt;
      found_r <= found_nxt;
      j_r     <= j_nxt;
      mrun_r  <= mrun_nxt;
      d_op_r  <= d_op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    d_mem_r   <= d_mem_nxt;
    d_first_r <= d_first_nxt;
    d_row_r   <= d_row_nxt;
    d_col_r   <= d_col_nxt;
    d_cost_r  <= d_cost_nxt;
    if (ld_city) begin
      cx_r[ccnt_r[IDX_W-1:0]] <= x_in;
      cy_r[ccnt_r[IDX_W-1:0]] <= y_in;
    end
    if (ld_plant) begin
      px_r[pcnt_r[IDX_W-1:0]] <= x_in;
      py_r[pcnt_r[IDX_W-1:0]] <= y_in;
    end
    if (we) begin
      zero_r[d_row_r][d_col_r] <= (wdata == '0);
    end
  end

  a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request taken while results are pending");

  a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("block not ready after final result");

  a_match_owned: assert property (@(posedge clk) disable iff (!rst_n)
    mstat.done |-> ((st_r == ST_MATCH) || !mrun_r))
    else $error("matcher finished outside matching phase");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_LOAD) |-> ((ccnt_r <= n_act) && (pcnt_r <= n_act)))
    else $error("load count beyond point count");

endmodule

>>> hdl/mas_cost_ram.sv
// ---------------------------------------------------------------------------
// Cost matrix memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module mas_cost_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/mas_alu.sv
// ---------------------------------------------------------------------------
// Shared cost unit
// One add/subtract and one magnitude compare, reused by every matrix sweep.
// ---------------------------------------------------------------------------
module mas_alu #(
  parameter int W = 20
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         add,
  output logic [W-1:0] sum,
  output logic         less
);

  assign sum  = add ? (a + b) : (a - b);
  assign less = (a < b);

endmodule

>>> hdl/mas_match.sv
// ---------------------------------------------------------------------------
// Zero-entry matcher
// Builds a maximum matching on the zero entries with depth-first augmenting
// paths, one search step per cycle, using an explicit frame stack.
// ---------------------------------------------------------------------------
module mas_match #(
  parameter int MAX_POINTS = 16
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          start,
  input  logic [$clog2(MAX_POINTS):0]                   n_act,
  input  logic [MAX_POINTS-1:0]                         zero_row,
  output logic [$clog2(MAX_POINTS)-1:0]                 row_q,
  input  logic [$clog2(MAX_POINTS)-1:0]                 rd_col,
  output logic [$clog2(MAX_POINTS):0]                   match_q,
  output logic [MAX_POINTS-1:0][$clog2(MAX_POINTS):0]   match_o,
  output logic [MAX_POINTS-1:0]                         matched_o,
  output mas_pkg::mt_stat_t                             stat
);
  import mas_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] NO_M = CNT_W'(MAX_POINTS);

  mt_t                                mt_r, mt_nxt;
  logic [CNT_W-1:0]                   root_r, root_nxt;
  logic                               ok_r, ok_nxt;
  logic [MAX_POINTS-1:0]              seen_r, seen_nxt;
  logic [IDX_W-1:0]                   sp_r, sp_nxt;
  logic                               resume_r, resume_nxt;
  logic [IDX_W-1:0]                   frow_r [MAX_POINTS];
  logic [IDX_W-1:0]                   fcol_r [MAX_POINTS];
  logic [MAX_POINTS-1:0][CNT_W-1:0]   match_r, match_nxt;
  logic [MAX_POINTS-1:0]              matched_r, matched_nxt;

  logic [IDX_W-1:0]      cur_row, cur_col;
  logic [CNT_W-1:0]      start_col;
  logic [MAX_POINTS-1:0] act, cand;
  logic [IDX_W-1:0]      pick, mrd;
  logic                  hit;
  logic [CNT_W-1:0]      mval;

  assign cur_row   = frow_r[sp_r];
  assign cur_col   = fcol_r[sp_r];
  assign row_q     = cur_row;
  assign start_col = resume_r ? (CNT_W'(cur_col) + CNT_W'(1)) : '0;

  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      act[i]  = (CNT_W'(i) < n_act);
      cand[i] = zero_row[i] && !seen_r[i] && act[i] && (CNT_W'(i) >= start_col);
    end
  end

  // Lowest candidate column wins, as the column scan runs upward.
  always_comb begin
    pick = '0;
    for (int i = MAX_POINTS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick = IDX_W'(i);
      end
    end
  end
  assign hit = |cand;

  assign mrd       = (mt_r == MT_IDLE) ? rd_col : pick;
  assign mval      = match_r[mrd];
  assign match_q   = mval;
  assign match_o   = match_r;
  assign matched_o = matched_r;

  assign stat.done     = (mt_r == MT_ROOT) && (root_r == n_act);
  assign stat.complete = ok_r;

  always_comb begin
    mt_nxt = mt_r;
    case (mt_r)
      MT_IDLE: begin
        if (start) begin
          mt_nxt = MT_ROOT;
        end
      end
      MT_ROOT: begin
        mt_nxt = (root_r == n_act) ? MT_IDLE : MT_SEARCH;
      end
      MT_SEARCH: begin
        if (hit) begin
          if (mval == NO_M) begin
            mt_nxt = MT_UNWIND;
          end
        end else if (sp_r == '0) begin
          mt_nxt = MT_ROOT;
        end
      end
      MT_UNWIND: begin
        if (sp_r == '0) begin
          mt_nxt = MT_ROOT;
        end
      end
      default: mt_nxt = MT_IDLE;
    endcase
  end

  always_comb begin
    root_nxt    = root_r;
    ok_nxt      = ok_r;
    seen_nxt    = seen_r;
    sp_nxt      = sp_r;
    resume_nxt  = resume_r;
    match_nxt   = match_r;
    matched_nxt = matched_r;
    case (mt_r)
      MT_IDLE: begin
        if (start) begin
          for (int i = 0; i < MAX_POINTS; i++) begin
            match_nxt[i] = NO_M;
          end
          matched_nxt = '0;
          root_nxt    = '0;
          ok_nxt      = 1'b1;
        end
      end
      MT_ROOT: begin
        seen_nxt   = '0;
        sp_nxt     = '0;
        resume_nxt = 1'b0;
      end
      MT_SEARCH: begin
        if (hit) begin
          seen_nxt[pick] = 1'b1;
          if (mval != NO_M) begin
            sp_nxt     = sp_r + IDX_W'(1);
            resume_nxt = 1'b0;
          end
        end else if (sp_r == '0) begin
          ok_nxt   = 1'b0;
          root_nxt = root_r + CNT_W'(1);
        end else begin
          sp_nxt     = sp_r - IDX_W'(1);
          resume_nxt = 1'b1;
        end
      end
      MT_UNWIND: begin
        match_nxt[cur_col] = CNT_W'(cur_row);
        if (sp_r == '0) begin
          matched_nxt[cur_row] = 1'b1;
          root_nxt             = root_r + CNT_W'(1);
        end else begin
          sp_nxt = sp_r - IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mt_r      <= MT_IDLE;
      root_r    <= '0;
      ok_r      <= 1'b0;
      sp_r      <= '0;
      resume_r  <= 1'b0;
      seen_r    <= '0;
      matched_r <= '0;
      for (int i = 0; i < MAX_POINTS; i++) begin
        match_r[i] <= NO_M;
      end
    end else begin
      mt_r      <= mt_nxt;
      root_r    <= root_nxt;
      ok_r      <= ok_nxt;
      sp_r      <= sp_nxt;
      resume_r  <= resume_nxt;
      seen_r    <= seen_nxt;
      matched_r <= matched_nxt;
      match_r   <= match_nxt;
    end
  end

  // Frame stack contents.
  always_ff @(posedge clk) begin
    if (mt_r == MT_ROOT) begin
      frow_r[0] <= root_r[IDX_W-1:0];
    end
    if (mt_r == MT_SEARCH && hit) begin
      fcol_r[sp_r] <= pick;
      if (mval != NO_M) begin
        frow_r[sp_r + IDX_W'(1)] <= mval[IDX_W-1:0];
      end
    end
  end

endmodule
